FILE: sv/gcd_pkg.sv
`default_nettype none
package gcd_pkg;

   localparam int CORDIC_STEPS_DEF = 32;
   localparam int LANES = 5;
   localparam int LANE_A = 0;
   localparam int LANE_B = 1;
   localparam int LANE_DLAT = 2;
   localparam int LANE_SLAT = 3;
   localparam int LANE_DLON = 4;

   localparam int ANG_W = 34;
   localparam int XY_W = 44;
   localparam int Z_W = 44;
   localparam int Q30_W = 32;
   localparam int VX_W = 48;
   localparam int ARC_W = 43;
   localparam int RAD_W = 23;
   localparam int R100_W = 30;
   localparam int DATA_W = 32;
   localparam int PADDR_W = 3;

   localparam logic [PADDR_W-3:0] REG_RADIUS = '0;
   localparam logic [RAD_W-1:0] RADIUS_RESET = 23'd6371000;
   localparam logic [R100_W-1:0] R100_RESET = 30'd637100000;

   localparam logic signed [ANG_W-1:0] TURN = 34'sd7200000000;
   localparam logic [ANG_W-2:0] QUARTER_1 = 33'd1800000000;
   localparam logic [ANG_W-2:0] QUARTER_2 = 33'd3600000000;
   localparam logic [ANG_W-2:0] QUARTER_3 = 33'd5400000000;

   localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
   localparam logic [63:0] DEG_DIV = 64'd3600000000;
   localparam logic [63:0] DEG_Q = PI_Q60 / DEG_DIV;
   localparam logic [63:0] DEG_R = PI_Q60 % DEG_DIV;
   localparam logic [127:0] DEG_K = ({64'd0, DEG_R} << 32) / {64'd0, DEG_DIV};
   localparam logic [29:0] DEG_Q30 = DEG_Q[29:0];
   localparam logic [31:0] DEG_R32 = DEG_R[31:0];
   localparam logic [31:0] DEG_K32 = DEG_K[31:0];
   localparam logic [33:0] DEG_D34 = DEG_DIV[33:0];

   localparam logic signed [XY_W-1:0] GAIN_INV_Q40 = 44'sd667681663043;

   typedef enum logic [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} quad_type;

   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[63:0], num[b]};
         if (r >= {1'b0, den}) begin
            r = r - {1'b0, den};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic signed [Z_W-1:0] atan_q40(input int i);
      logic [63:0] sum;
      logic [63:0] term;
      int e;
      sum = '0;
      if (i == 0) begin
         sum = PI_Q60;
      end else begin
         for (int k = 0; k < 64; k++) begin
            e = i * (2 * k + 1);
            if (e <= 62) begin
               term = udiv64(64'd1 << (62 - e), 64'(2 * k + 1));
               if ((k & 1) == 1) sum = sum - term;
               else sum = sum + term;
            end
         end
      end
      return Z_W'((sum + (64'd1 << 21)) >> 22);
   endfunction

   function automatic logic signed [XY_W-1:0] gain_init(input int steps);
      logic signed [XY_W-1:0] g;
      g = GAIN_INV_Q40;
      if (2 * steps - 1 < 63) g = g + ((GAIN_INV_Q40 >>> (2 * steps - 1)) / 3);
      return g;
   endfunction

   function automatic int gcd_latency(input int steps);
      return 2 * steps + 46;
   endfunction

endpackage
`default_nettype wire

FILE: sv/gcd_sincos.sv
`default_nettype none
module gcd_sincos #(
   parameter int CORDIC_STEPS = gcd_pkg::CORDIC_STEPS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic signed [gcd_pkg::ANG_W-1:0] in_angle [gcd_pkg::LANES],
   output logic out_valid,
   output logic signed [gcd_pkg::Q30_W-1:0] out_sin [gcd_pkg::LANES],
   output logic signed [gcd_pkg::Q30_W-1:0] out_cos [gcd_pkg::LANES]
);
   import gcd_pkg::*;

   localparam logic signed [XY_W-1:0] X_INIT = gain_init(CORDIC_STEPS);

   logic va_ff, vb_ff, vc_ff, vd_ff, vo_ff;
   logic signed [ANG_W-1:0] ang_ff [LANES];

   logic [ANG_W-2:0] red_in [LANES];
   quad_type quad_in [LANES];
   logic [30:0] rem_in [LANES];
   quad_type qb_ff [LANES], qc_ff [LANES], qd_ff [LANES];
   logic [30:0] rem_ff [LANES];

   logic [60:0] mq_ff [LANES], mq_d_ff [LANES];
   logic [62:0] mk_ff [LANES];
   logic [33:0] mr_ff [LANES], mr_d_ff [LANES];
   logic [30:0] qa_ff [LANES];
   logic [33:0] md_ff [LANES];

   logic [33:0] rmd_in [LANES];
   logic [31:0] qfix_in [LANES];
   logic [60:0] t60_in [LANES];

   logic signed [XY_W-1:0] rx_ff [CORDIC_STEPS+1][LANES];
   logic signed [XY_W-1:0] ry_ff [CORDIC_STEPS+1][LANES];
   logic signed [Z_W-1:0] rz_ff [CORDIC_STEPS+1][LANES];
   quad_type rq_ff [CORDIC_STEPS+1][LANES];
   logic rv_ff [CORDIC_STEPS+1];

   logic signed [Q30_W-1:0] xs_in [LANES], ys_in [LANES];
   logic signed [Q30_W-1:0] sin_in [LANES], cos_in [LANES];
   logic signed [Q30_W-1:0] sin_ff [LANES], cos_ff [LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         rv_ff[0] <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
         rv_ff[0] <= vd_ff;
         vo_ff <= rv_ff[CORDIC_STEPS];
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         red_in[l] = (ang_ff[l] < 0) ? (ANG_W-1)'(ang_ff[l] + TURN) : (ANG_W-1)'(ang_ff[l]);
         if (red_in[l] >= QUARTER_3) begin
            quad_in[l] = QUAD_IV;
            rem_in[l] = 31'(red_in[l] - QUARTER_3);
         end else if (red_in[l] >= QUARTER_2) begin
            quad_in[l] = QUAD_III;
            rem_in[l] = 31'(red_in[l] - QUARTER_2);
         end else if (red_in[l] >= QUARTER_1) begin
            quad_in[l] = QUAD_II;
            rem_in[l] = 31'(red_in[l] - QUARTER_1);
         end else begin
            quad_in[l] = QUAD_I;
            rem_in[l] = 31'(red_in[l]);
         end
         rmd_in[l] = mr_d_ff[l] - md_ff[l];
         qfix_in[l] = (rmd_in[l] >= DEG_D34) ? {1'b0, qa_ff[l]} + 32'd1 : {1'b0, qa_ff[l]};
         t60_in[l] = mq_d_ff[l] + 61'(qfix_in[l]);
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < LANES; l++) begin
         ang_ff[l] <= in_angle[l];
         qb_ff[l] <= quad_in[l];
         rem_ff[l] <= rem_in[l];
         qc_ff[l] <= qb_ff[l];
         mq_ff[l] <= 61'(rem_ff[l]) * 61'(DEG_Q30);
         mk_ff[l] <= 63'(rem_ff[l]) * 63'(DEG_K32);
         mr_ff[l] <= 34'(rem_ff[l]) * 34'(DEG_R32);
         qd_ff[l] <= qc_ff[l];
         qa_ff[l] <= mk_ff[l][62:32];
         md_ff[l] <= 34'(mk_ff[l][62:32]) * DEG_D34;
         mq_d_ff[l] <= mq_ff[l];
         mr_d_ff[l] <= mr_ff[l];
         rx_ff[0][l] <= X_INIT;
         ry_ff[0][l] <= '0;
         rz_ff[0][l] <= Z_W'((t60_in[l] + 61'd524288) >> 20);
         rq_ff[0][l] <= qd_ff[l];
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      localparam logic signed [Z_W-1:0] ATAN = atan_q40(i);

      always_ff @(posedge clock) begin
         if (reset) rv_ff[i+1] <= 1'b0;
         else rv_ff[i+1] <= rv_ff[i];
      end

      always_ff @(posedge clock) begin
         for (int l = 0; l < LANES; l++) begin
            rq_ff[i+1][l] <= rq_ff[i][l];
            if (!rz_ff[i][l][Z_W-1]) begin
               rx_ff[i+1][l] <= rx_ff[i][l] - (ry_ff[i][l] >>> i);
               ry_ff[i+1][l] <= ry_ff[i][l] + (rx_ff[i][l] >>> i);
               rz_ff[i+1][l] <= rz_ff[i][l] - ATAN;
            end else begin
               rx_ff[i+1][l] <= rx_ff[i][l] + (ry_ff[i][l] >>> i);
               ry_ff[i+1][l] <= ry_ff[i][l] - (rx_ff[i][l] >>> i);
               rz_ff[i+1][l] <= rz_ff[i][l] + ATAN;
            end
         end
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         xs_in[l] = Q30_W'((rx_ff[CORDIC_STEPS][l] + 44'sd512) >>> 10);
         ys_in[l] = Q30_W'((ry_ff[CORDIC_STEPS][l] + 44'sd512) >>> 10);
         case (rq_ff[CORDIC_STEPS][l])
            QUAD_I: begin
               cos_in[l] = xs_in[l];
               sin_in[l] = ys_in[l];
            end
            QUAD_II: begin
               cos_in[l] = -ys_in[l];
               sin_in[l] = xs_in[l];
            end
            QUAD_III: begin
               cos_in[l] = -xs_in[l];
               sin_in[l] = -ys_in[l];
            end
            default: begin
               cos_in[l] = ys_in[l];
               sin_in[l] = -xs_in[l];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < LANES; l++) begin
         sin_ff[l] <= sin_in[l];
         cos_ff[l] <= cos_in[l];
      end
   end

   assign out_valid = vo_ff;
   assign out_sin = sin_ff;
   assign out_cos = cos_ff;

endmodule
`default_nettype wire

FILE: sv/gcd_arc.sv
`default_nettype none
module gcd_arc #(
   parameter int CORDIC_STEPS = gcd_pkg::CORDIC_STEPS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic [63:0] in_h,
   input  logic [63:0] in_g,
   output logic out_valid,
   output logic [gcd_pkg::ARC_W-1:0] out_angle
);
   import gcd_pkg::*;

   localparam int ROOT_STEPS = 32;

   logic [63:0] nh_ff [ROOT_STEPS+1], rh_ff [ROOT_STEPS+1];
   logic [63:0] ng_ff [ROOT_STEPS+1], rg_ff [ROOT_STEPS+1];
   logic sv_ff [ROOT_STEPS+1];

   logic signed [VX_W-1:0] vx_ff [CORDIC_STEPS+1], vy_ff [CORDIC_STEPS+1];
   logic signed [Z_W-1:0] vz_ff [CORDIC_STEPS+1];
   logic vv_ff [CORDIC_STEPS+1];

   logic ov_ff;
   logic [ARC_W-1:0] ang_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff[0] <= 1'b0;
         vv_ff[0] <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         sv_ff[0] <= in_valid;
         vv_ff[0] <= sv_ff[ROOT_STEPS];
         ov_ff <= vv_ff[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      nh_ff[0] <= in_h;
      rh_ff[0] <= '0;
      ng_ff[0] <= in_g;
      rg_ff[0] <= '0;
      vx_ff[0] <= VX_W'(rg_ff[ROOT_STEPS][31:0]) <<< 10;
      vy_ff[0] <= VX_W'(rh_ff[ROOT_STEPS][31:0]) <<< 10;
      vz_ff[0] <= '0;
      ang_ff <= vz_ff[CORDIC_STEPS][Z_W-1] ? '0 : ARC_W'(vz_ff[CORDIC_STEPS]) << 1;
   end

   for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_root
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
      logic [63:0] th_in, tg_in;

      assign th_in = rh_ff[j] + BIT;
      assign tg_in = rg_ff[j] + BIT;

      always_ff @(posedge clock) begin
         if (reset) sv_ff[j+1] <= 1'b0;
         else sv_ff[j+1] <= sv_ff[j];
      end

      always_ff @(posedge clock) begin
         if (nh_ff[j] >= th_in) begin
            nh_ff[j+1] <= nh_ff[j] - th_in;
            rh_ff[j+1] <= (rh_ff[j] >> 1) + BIT;
         end else begin
            nh_ff[j+1] <= nh_ff[j];
            rh_ff[j+1] <= rh_ff[j] >> 1;
         end
         if (ng_ff[j] >= tg_in) begin
            ng_ff[j+1] <= ng_ff[j] - tg_in;
            rg_ff[j+1] <= (rg_ff[j] >> 1) + BIT;
         end else begin
            ng_ff[j+1] <= ng_ff[j];
            rg_ff[j+1] <= rg_ff[j] >> 1;
         end
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
      localparam logic signed [Z_W-1:0] ATAN = atan_q40(i);

      always_ff @(posedge clock) begin
         if (reset) vv_ff[i+1] <= 1'b0;
         else vv_ff[i+1] <= vv_ff[i];
      end

      always_ff @(posedge clock) begin
         if (vy_ff[i] > 0) begin
            vx_ff[i+1] <= vx_ff[i] + (vy_ff[i] >>> i);
            vy_ff[i+1] <= vy_ff[i] - (vx_ff[i] >>> i);
            vz_ff[i+1] <= vz_ff[i] + ATAN;
         end else begin
            vx_ff[i+1] <= vx_ff[i] - (vy_ff[i] >>> i);
            vy_ff[i+1] <= vy_ff[i] + (vx_ff[i] >>> i);
            vz_ff[i+1] <= vz_ff[i] - ATAN;
         end
      end
   end

   assign out_valid = ov_ff;
   assign out_angle = ang_ff;

endmodule
`default_nettype wire

FILE: sv/great_circle_distance_top.sv
// Channel   Ports                                      Handshake
// request   req_lat_a req_lon_a req_lat_b req_lon_b    start high, busy low
// result    rsp_distance_cm                            rsp_valid, one cycle
// csr       psel penable pwrite paddr pwdata prdata    pready, always high
//
// One request per cycle while busy is low; each result follows its request in order.
// The rotation and vectoring CORDIC chains, one step per stage, and the
// 32-stage square root set the latency.
// busy follows reset; a request during reset is not taken.
// The receiver cannot stall; nothing holds the pipeline.
`default_nettype none
module great_circle_distance_top #(
   parameter int CORDIC_STEPS = gcd_pkg::CORDIC_STEPS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic signed [30:0] req_lat_a,
   input  logic signed [31:0] req_lon_a,
   input  logic signed [30:0] req_lat_b,
   input  logic signed [31:0] req_lon_b,
   output logic rsp_valid,
   output logic [31:0] rsp_distance_cm,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [gcd_pkg::PADDR_W-1:0] paddr,
   input  logic [gcd_pkg::DATA_W-1:0] pwdata,
   output logic [gcd_pkg::DATA_W-1:0] prdata,
   output logic pready
);
   import gcd_pkg::*;

   logic [RAD_W-1:0] radius_ff;
   logic [R100_W-1:0] r100_ff;
   logic csr_write;

   logic signed [ANG_W-1:0] ang_in [LANES];
   logic sc_valid;
   logic signed [Q30_W-1:0] sc_sin [LANES], sc_cos [LANES];

   logic v1_ff, v2_ff, v3_ff, vf1_ff, rsp_valid_ff;
   logic signed [63:0] p_c1sn_ff, p_c2sn_ff, p_c1cn_ff, p_c2cn_ff;
   logic signed [63:0] p_sd2_ff, p_ss2_ff, p_sd2_d_ff, p_ss2_d_ff;
   logic signed [Q30_W-1:0] u1_ff, u2_ff, w1_ff, w2_ff;
   logic signed [63:0] uu_ff, ww_ff, sd2_ff, ss2_ff;
   logic signed [63:0] h_in, g_in;

   logic arc_valid;
   logic [ARC_W-1:0] arc_angle;

   logic [52:0] ph_ff;
   logic [49:0] pl_ff;
   logic [53:0] acc_in;
   logic [33:0] dist_in;
   logic [31:0] rsp_dist_ff;

   assign busy = reset;
   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_RADIUS);
   assign prdata = (paddr[PADDR_W-1:2] == REG_RADIUS) ?
                   DATA_W'(radius_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
         r100_ff <= R100_RESET;
      end else if (csr_write) begin
         radius_ff <= pwdata[RAD_W-1:0];
         r100_ff <= R100_W'(pwdata[RAD_W-1:0]) * 30'd100;
      end
   end

   always_comb begin
      ang_in[LANE_A] = ANG_W'(req_lat_a) <<< 1;
      ang_in[LANE_B] = ANG_W'(req_lat_b) <<< 1;
      ang_in[LANE_DLAT] = ANG_W'(req_lat_b) - ANG_W'(req_lat_a);
      ang_in[LANE_SLAT] = ANG_W'(req_lat_a) + ANG_W'(req_lat_b);
      ang_in[LANE_DLON] = ANG_W'(req_lon_b) - ANG_W'(req_lon_a);
   end

   gcd_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sincos (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_angle  (ang_in),
      .out_valid (sc_valid),
      .out_sin   (sc_sin),
      .out_cos   (sc_cos)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vf1_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff <= sc_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         vf1_ff <= arc_valid;
         rsp_valid_ff <= vf1_ff;
      end
   end

   always_ff @(posedge clock) begin
      p_c1sn_ff <= 64'(sc_cos[LANE_A]) * 64'(sc_sin[LANE_DLON]);
      p_c2sn_ff <= 64'(sc_cos[LANE_B]) * 64'(sc_sin[LANE_DLON]);
      p_c1cn_ff <= 64'(sc_cos[LANE_A]) * 64'(sc_cos[LANE_DLON]);
      p_c2cn_ff <= 64'(sc_cos[LANE_B]) * 64'(sc_cos[LANE_DLON]);
      p_sd2_ff <= 64'(sc_sin[LANE_DLAT]) * 64'(sc_sin[LANE_DLAT]);
      p_ss2_ff <= 64'(sc_sin[LANE_SLAT]) * 64'(sc_sin[LANE_SLAT]);

      u1_ff <= Q30_W'((p_c1sn_ff + 64'sd536870912) >>> 30);
      u2_ff <= Q30_W'((p_c2sn_ff + 64'sd536870912) >>> 30);
      w1_ff <= Q30_W'((p_c1cn_ff + 64'sd536870912) >>> 30);
      w2_ff <= Q30_W'((p_c2cn_ff + 64'sd536870912) >>> 30);
      p_sd2_d_ff <= p_sd2_ff;
      p_ss2_d_ff <= p_ss2_ff;

      uu_ff <= 64'(u1_ff) * 64'(u2_ff);
      ww_ff <= 64'(w1_ff) * 64'(w2_ff);
      sd2_ff <= p_sd2_d_ff;
      ss2_ff <= p_ss2_d_ff;
   end

   assign h_in = sd2_ff + uu_ff;
   assign g_in = ss2_ff + ww_ff;

   gcd_arc #(.CORDIC_STEPS(CORDIC_STEPS)) u_arc (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v3_ff),
      .in_h      (h_in[63] ? 64'd0 : h_in),
      .in_g      (g_in[63] ? 64'd0 : g_in),
      .out_valid (arc_valid),
      .out_angle (arc_angle)
   );

   assign acc_in = 54'(ph_ff) + 54'(pl_ff >> 20);
   assign dist_in = 34'((acc_in + 54'd524288) >> 20);

   always_ff @(posedge clock) begin
      ph_ff <= 53'(r100_ff) * 53'(arc_angle[ARC_W-1:20]);
      pl_ff <= 50'(r100_ff) * 50'(arc_angle[19:0]);
      rsp_dist_ff <= (dist_in[33:32] != 2'd0) ? 32'hFFFF_FFFF : dist_in[31:0];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_distance_cm = rsp_dist_ff;

endmodule
`default_nettype wire

FILE: sv/gcd_checker.sv
`default_nettype none
module gcd_checker #(
   parameter int CORDIC_STEPS = gcd_pkg::CORDIC_STEPS_DEF
) (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic psel,
   input logic penable,
   input logic pwrite,
   input logic pready,
   input logic [gcd_pkg::PADDR_W-1:0] paddr,
   input logic [gcd_pkg::DATA_W-1:0] pwdata,
   input logic [gcd_pkg::DATA_W-1:0] prdata
);
   import gcd_pkg::*;

   localparam int LATENCY = gcd_latency(CORDIC_STEPS);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe after reset");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("request lost");

   a_result_caused: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without request");

   a_readback: assert property (@(posedge clock)
      (psel && penable && pwrite && pready && !reset &&
       paddr[PADDR_W-1:2] == REG_RADIUS)
      |=> (paddr[PADDR_W-1:2] != REG_RADIUS ||
           prdata == DATA_W'($past(pwdata[RAD_W-1:0]))))
      else $error("radius readback mismatch");

endmodule

bind great_circle_distance_top gcd_checker #(.CORDIC_STEPS(CORDIC_STEPS)) u_gcd_checker (.*);
`default_nettype wire
